FILE: rtl/core/pet_pkg.sv
// Shared types and constants of the PID error tracker.
`timescale 1ns / 1ps
package pet_pkg;

  localparam int unsigned WARMUP_STEPS = 500;
  localparam int unsigned INTEG_PERIOD = 10;
  localparam int unsigned INTEG_LIMIT  = 4608;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PROP_W   = 32;
  localparam int unsigned INTEG_W  = 14;
  localparam int unsigned DERIV_W  = 17;
  localparam int unsigned STEP_W   = 9;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned OPA_W    = 33;
  localparam int unsigned PROD_W   = OPA_W + GAIN_W;
  localparam int unsigned ACC_W    = 52;
  localparam int unsigned DRIVE_W  = 32;
  localparam int unsigned FRAC_SH  = 12;

  localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
  localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
  localparam logic [1:0] REG_GAIN_DERIV = 2'd2;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

FILE: rtl/core/pet_mac.sv
// Shared multiplier with signed and magnitude accumulators.
`timescale 1ns / 1ps
module pet_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pet_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [pet_pkg::OPA_W-1:0]     op_a_i,
  input  logic signed [pet_pkg::GAIN_W-1:0]    op_b_i,
  output logic signed [pet_pkg::PROD_W-1:0]    prod_o,
  output logic signed [pet_pkg::ACC_W-1:0]     sum_o,
  output logic signed [pet_pkg::ACC_W-1:0]     mag_o
);

  logic signed [pet_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                              neg_q;
  logic signed [pet_pkg::ACC_W-1:0]  sum_q, mag_q, prod_ext;

  assign prod_d   = op_a_i * op_b_i;
  assign prod_ext = {{(pet_pkg::ACC_W - pet_pkg::PROD_W){prod_q[pet_pkg::PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else if (ctrl_i.mul_en) begin
      neg_q <= op_a_i[pet_pkg::OPA_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.clear) begin
      sum_q <= '0;
      mag_q <= '0;
    end else if (ctrl_i.acc_en) begin
      sum_q <= sum_q + prod_ext;
      mag_q <= neg_q ? (mag_q - prod_ext) : (mag_q + prod_ext);
    end
  end

  assign prod_o = prod_q;
  assign sum_o  = sum_q;
  assign mag_o  = mag_q;

endmodule

FILE: rtl/core/pid_error_tracker.sv
// Top level of the PID error tracker: sequencer, state, gains and output register.
//
// Usage: error samples (signed Q8.8) arrive on the s_axis stream, one per
// transfer. Each sample updates the proportional and derivative terms (every
// tenth past warmup also the integral term) and yields one m_axis transfer
// carrying two saturated Q24.8 drives: the negated gain-weighted sum and the
// negated sum over absolute terms. Gains are written over the APB port (0x0
// prop, 0x4 integ, 0x8 deriv, signed Q4.12) while no sample is in flight.
// Path: a sample passes ST_MULP, ST_MULI, ST_MULD, ST_ACC and ST_FIN to the
// output register; the first sample after reset passes ST_CUBE1, ST_CUBE2 and
// ST_CUBE3 before them, for two extra multiplies and a scale step for the cube.
// s_axis_tready is low while a sample is being worked, so a new sample is taken
// only once the last one has left ST_FIN. The three gain products run one after
// another through one shared multiplier and two accumulators.
// The output register holds one result; the next sample is taken and worked
// while it waits, and the sequencer holds in its last step while a stalled
// result is still pending.
// Reset clears all terms, history, step count, phase and gains; the first
// sample after reset takes the cube path.
`timescale 1ns / 1ps
module pid_error_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] error_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] drive_signed, [63:32] drive_magnitude
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CUBE1 = 4'd1;
  localparam logic [3:0] ST_CUBE2 = 4'd2;
  localparam logic [3:0] ST_CUBE3 = 4'd3;
  localparam logic [3:0] ST_MULP  = 4'd4;
  localparam logic [3:0] ST_MULI  = 4'd5;
  localparam logic [3:0] ST_MULD  = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam int unsigned SH_W = pet_pkg::ACC_W - pet_pkg::FRAC_SH;

  logic [3:0] state_q, state_d;

  logic signed [pet_pkg::GAIN_W-1:0]   gain_prop_q, gain_integ_q, gain_deriv_q;
  logic signed [pet_pkg::PROP_W-1:0]   prop_q, prop_d;
  logic signed [pet_pkg::INTEG_W-1:0]  integ_q, integ_d;
  logic signed [pet_pkg::DERIV_W-1:0]  deriv_q, deriv_d;
  logic signed [pet_pkg::SAMPLE_W-1:0] last_q, last_d, second_q, second_d, sample_q, e;
  logic [pet_pkg::STEP_W-1:0]          step_q, step_d;
  logic [pet_pkg::PHASE_W-1:0]         phase_q, phase_d;

  logic                                in_xfer, cfg_wr, out_load;
  logic signed [19:0]                  e20, l20, s20, acc20;

  pet_pkg::mac_ctrl_t                  mac_ctrl;
  logic signed [pet_pkg::OPA_W-1:0]    op_a;
  logic signed [pet_pkg::GAIN_W-1:0]   op_b;
  logic signed [pet_pkg::PROD_W-1:0]   prod;
  logic signed [pet_pkg::ACC_W-1:0]    sum, mag, sum_neg, mag_neg;
  logic signed [SH_W-1:0]              sum_sh, mag_sh;
  logic signed [pet_pkg::DRIVE_W-1:0]  drv_sig, drv_mag;
  logic                                out_valid_q;
  logic [63:0]                         out_data_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        pet_pkg::REG_GAIN_PROP:  gain_prop_q  <= pwdata[15:0];
        pet_pkg::REG_GAIN_INTEG: gain_integ_q <= pwdata[15:0];
        pet_pkg::REG_GAIN_DERIV: gain_deriv_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pet_pkg::REG_GAIN_PROP:  prdata = {{16{gain_prop_q[15]}}, gain_prop_q};
      pet_pkg::REG_GAIN_INTEG: prdata = {{16{gain_integ_q[15]}}, gain_integ_q};
      pet_pkg::REG_GAIN_DERIV: prdata = {{16{gain_deriv_q[15]}}, gain_deriv_q};
      default:                 prdata = '0;
    endcase
  end

  // term update at transfer
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign e             = s_axis_tdata;

  assign e20   = {{4{e[15]}}, e};
  assign l20   = {{4{last_q[15]}}, last_q};
  assign s20   = {{4{second_q[15]}}, second_q};
  assign acc20 = {{6{integ_q[pet_pkg::INTEG_W-1]}}, integ_q} + (e20 <<< 1) + e20
               + (l20 <<< 2) + (s20 <<< 1) + s20;

  always_comb begin
    prop_d   = prop_q;
    integ_d  = integ_q;
    deriv_d  = deriv_q;
    last_d   = last_q;
    second_d = second_q;
    step_d   = step_q;
    phase_d  = phase_q;
    if (in_xfer) begin
      if (step_q == '0) begin
        integ_d = '0;
        deriv_d = '0;
        last_d  = e;
      end else begin
        prop_d  = {{(pet_pkg::PROP_W - pet_pkg::SAMPLE_W){e[15]}}, e};
        deriv_d = {e[15], e} - {last_q[15], last_q};
        if (phase_q == '0) begin
          if (acc20 > 20'sd4608) begin
            integ_d = pet_pkg::INTEG_W'(pet_pkg::INTEG_LIMIT);
          end else if (acc20 < -20'sd4608) begin
            integ_d = -pet_pkg::INTEG_W'(pet_pkg::INTEG_LIMIT);
          end else begin
            integ_d = acc20[pet_pkg::INTEG_W-1:0];
          end
        end
        if (step_q < pet_pkg::STEP_W'(pet_pkg::WARMUP_STEPS)) begin
          integ_d = '0;
        end
        second_d = last_q;
        last_d   = e;
      end
      if (step_q < pet_pkg::STEP_W'(pet_pkg::WARMUP_STEPS)) begin
        step_d = step_q + 1'b1;
      end
      if (phase_q + 1'b1 >= pet_pkg::PHASE_W'(pet_pkg::INTEG_PERIOD)) begin
        phase_d = '0;
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end else if (state_q == ST_CUBE3) begin
      prop_d = prod[47:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q   <= '0;
      integ_q  <= '0;
      deriv_q  <= '0;
      last_q   <= '0;
      second_q <= '0;
      step_q   <= '0;
      phase_q  <= '0;
    end else begin
      prop_q   <= prop_d;
      integ_q  <= integ_d;
      deriv_q  <= deriv_d;
      last_q   <= last_d;
      second_q <= second_d;
      step_q   <= step_d;
      phase_q  <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= e;
    end
  end

  // sequencer
  always_comb begin
    state_d         = state_q;
    mac_ctrl.clear  = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_en = 1'b0;
    op_a            = '0;
    op_b            = '0;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mac_ctrl.clear = 1'b1;
          state_d        = (step_q == '0) ? ST_CUBE1 : ST_MULP;
        end
      end
      ST_CUBE1: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = {{(pet_pkg::OPA_W - pet_pkg::SAMPLE_W){sample_q[15]}}, sample_q};
        op_b            = sample_q;
        state_d         = ST_CUBE2;
      end
      ST_CUBE2: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = prod[pet_pkg::OPA_W-1:0];
        op_b            = sample_q;
        state_d         = ST_CUBE3;
      end
      ST_CUBE3: begin
        state_d = ST_MULP;
      end
      ST_MULP: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = {prop_q[pet_pkg::PROP_W-1], prop_q};
        op_b            = gain_prop_q;
        state_d         = ST_MULI;
      end
      ST_MULI: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        op_a = {{(pet_pkg::OPA_W - pet_pkg::INTEG_W){integ_q[pet_pkg::INTEG_W-1]}}, integ_q};
        op_b            = gain_integ_q;
        state_d         = ST_MULD;
      end
      ST_MULD: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        op_a = {{(pet_pkg::OPA_W - pet_pkg::DERIV_W){deriv_q[pet_pkg::DERIV_W-1]}}, deriv_q};
        op_b            = gain_deriv_q;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  pet_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .sum_o  (sum),
    .mag_o  (mag)
  );

  // negate, floor-shift and saturate
  assign sum_neg = -sum;
  assign mag_neg = -mag;
  assign sum_sh  = sum_neg[pet_pkg::ACC_W-1:pet_pkg::FRAC_SH];
  assign mag_sh  = mag_neg[pet_pkg::ACC_W-1:pet_pkg::FRAC_SH];

  always_comb begin
    if (sum_sh[SH_W-1:pet_pkg::DRIVE_W-1] == '0 ||
        sum_sh[SH_W-1:pet_pkg::DRIVE_W-1] == '1) begin
      drv_sig = sum_sh[pet_pkg::DRIVE_W-1:0];
    end else begin
      drv_sig = {sum_sh[SH_W-1], {(pet_pkg::DRIVE_W-1){~sum_sh[SH_W-1]}}};
    end
    if (mag_sh[SH_W-1:pet_pkg::DRIVE_W-1] == '0 ||
        mag_sh[SH_W-1:pet_pkg::DRIVE_W-1] == '1) begin
      drv_mag = mag_sh[pet_pkg::DRIVE_W-1:0];
    end else begin
      drv_mag = {mag_sh[SH_W-1], {(pet_pkg::DRIVE_W-1){~mag_sh[SH_W-1]}}};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {drv_mag, drv_sig};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= $signed(14'd4608)) && (integ_q >= -$signed(14'd4608)))
    else $error("integral term out of clamp range");

  a_integ_warmup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q != '0) |-> (step_q == pet_pkg::STEP_W'(pet_pkg::WARMUP_STEPS)))
    else $error("integral term nonzero during warmup");

  a_step_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= pet_pkg::STEP_W'(pet_pkg::WARMUP_STEPS))
    else $error("step count beyond warmup");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < pet_pkg::PHASE_W'(pet_pkg::INTEG_PERIOD))
    else $error("phase beyond period");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("ready right after a transfer");

endmodule

FILE: tb/sv/tb_pid_error_tracker.sv
// Self-checking testbench of the PID error tracker: stream stimulus, APB gains, predictor.
`timescale 1ns / 1ps
module tb_pid_error_tracker;

  localparam int unsigned N_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PH  = 123;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned DIR_N         = 20;

  localparam logic [3:0] ADDR_GAIN_PROP  = {pet_pkg::REG_GAIN_PROP, 2'b00};
  localparam logic [3:0] ADDR_GAIN_INTEG = {pet_pkg::REG_GAIN_INTEG, 2'b00};
  localparam logic [3:0] ADDR_GAIN_DERIV = {pet_pkg::REG_GAIN_DERIV, 2'b00};
  localparam logic [3:0] ADDR_UNMAPPED   = 4'hC;

  localparam longint DRV_MAX = 64'sd2147483647;
  localparam longint DRV_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [pet_pkg::DRIVE_W-1:0] drive_magnitude;
    logic signed [pet_pkg::DRIVE_W-1:0] drive_signed;
  } drive_t;

  typedef struct packed {
    logic [pet_pkg::SAMPLE_W-1:0] sample;
    logic                         typed;
    logic [pet_pkg::DRIVE_W-1:0]  want_signed;
    logic [pet_pkg::DRIVE_W-1:0]  want_magnitude;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] error_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [31:0] drive_signed, [63:32] drive_magnitude

  pid_error_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic signed [pet_pkg::GAIN_W-1:0]   kp_q, ki_q, kd_q;
  logic signed [pet_pkg::PROP_W-1:0]   prop_q;
  logic signed [pet_pkg::INTEG_W-1:0]  integ_q;
  logic signed [pet_pkg::DERIV_W-1:0]  deriv_q;
  logic signed [pet_pkg::SAMPLE_W-1:0] last_q, prev_q;
  logic [pet_pkg::STEP_W-1:0]          steps_q;
  logic [pet_pkg::PHASE_W-1:0]         phase_q;

  drive_t      pending_drives[$];
  int unsigned err_cnt     = 0;
  int unsigned n_samples   = 0;
  int unsigned n_drives    = 0;
  int unsigned n_settings  = 0;
  int unsigned n_integ     = 0;
  int unsigned stall_cnt   = 0;
  bit          no_idle     = 1'b0;
  bit          hold_req    = 1'b0;

  dir_row_t dir_rows [DIR_N] = '{
    '{16'h8000, 1'b1, 32'h8000_0000, 32'h7fff_ffff},
    '{16'h7fff, 1'b0, '0, '0},
    '{16'h0000, 1'b0, '0, '0},
    '{16'h0001, 1'b0, '0, '0},
    '{16'hffff, 1'b0, '0, '0},
    '{16'h0100, 1'b0, '0, '0},
    '{16'hff00, 1'b0, '0, '0},
    '{16'h5555, 1'b0, '0, '0},
    '{16'haaaa, 1'b0, '0, '0},
    '{16'h7fff, 1'b0, '0, '0},
    '{16'h7fff, 1'b0, '0, '0},
    '{16'h8000, 1'b0, '0, '0},
    '{16'h8000, 1'b0, '0, '0},
    '{16'h0000, 1'b0, '0, '0},
    '{16'h0010, 1'b0, '0, '0},
    '{16'hfff0, 1'b0, '0, '0},
    '{16'h1234, 1'b0, '0, '0},
    '{16'hedcb, 1'b0, '0, '0},
    '{16'h7fff, 1'b0, '0, '0},
    '{16'h8000, 1'b0, '0, '0}
  };

  function automatic logic signed [pet_pkg::DRIVE_W-1:0] sat32(input longint v);
    if (v > DRV_MAX) return DRV_MAX[pet_pkg::DRIVE_W-1:0];
    if (v < DRV_MIN) return DRV_MIN[pet_pkg::DRIVE_W-1:0];
    return v[pet_pkg::DRIVE_W-1:0];
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic drive_t track_error(input logic signed [pet_pkg::SAMPLE_W-1:0] e);
    longint ev, acc, p, i, d, s, m;
    drive_t r;
    ev = longint'(e);
    if (steps_q == 0) begin
      prop_q  = sat32((ev * ev * ev) >>> 16);
      integ_q = '0;
      deriv_q = '0;
      last_q  = e;
    end else begin
      prop_q  = ev[pet_pkg::PROP_W-1:0];
      deriv_q = pet_pkg::DERIV_W'(ev - longint'(last_q));
      if (phase_q == 0) begin
        acc = longint'(integ_q) + 3 * ev + 4 * longint'(last_q) + 3 * longint'(prev_q);
        if (acc > longint'(pet_pkg::INTEG_LIMIT)) acc = longint'(pet_pkg::INTEG_LIMIT);
        else if (acc < -longint'(pet_pkg::INTEG_LIMIT)) acc = -longint'(pet_pkg::INTEG_LIMIT);
        integ_q = acc[pet_pkg::INTEG_W-1:0];
        if (steps_q >= pet_pkg::WARMUP_STEPS) n_integ++;
      end
      if (steps_q < pet_pkg::WARMUP_STEPS) integ_q = '0;
      prev_q = last_q;
      last_q = e;
    end
    if (steps_q < pet_pkg::WARMUP_STEPS) steps_q = steps_q + 1'b1;
    phase_q = (phase_q + 1 >= pet_pkg::INTEG_PERIOD) ? '0 : phase_q + 1'b1;
    p = longint'(prop_q);
    i = longint'(integ_q);
    d = longint'(deriv_q);
    s = longint'(kp_q) * p + longint'(ki_q) * i + longint'(kd_q) * d;
    m = longint'(kp_q) * mag(p) + longint'(ki_q) * mag(i) + longint'(kd_q) * mag(d);
    r.drive_signed    = sat32((-s) >>> pet_pkg::FRAC_SH);
    r.drive_magnitude = sat32((-m) >>> pet_pkg::FRAC_SH);
    return r;
  endfunction

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_GAIN_PROP:  kp_q = data[pet_pkg::GAIN_W-1:0];
      ADDR_GAIN_INTEG: ki_q = data[pet_pkg::GAIN_W-1:0];
      ADDR_GAIN_DERIV: kd_q = data[pet_pkg::GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_gains(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd);
    apb_write(ADDR_GAIN_PROP,  {16'($urandom_range(0, 65535)), kp});
    apb_write(ADDR_GAIN_INTEG, {16'($urandom_range(0, 65535)), ki});
    apb_write(ADDR_GAIN_DERIV, {16'($urandom_range(0, 65535)), kd});
    apb_write(ADDR_UNMAPPED,   $urandom);
    n_settings++;
  endtask

  task automatic send_sample(input logic [pet_pkg::SAMPLE_W-1:0] e, input bit typed,
                             input drive_t typed_want);
    drive_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= e;
    do @(posedge clk_i); while (!s_axis_tready);
    want = track_error(e);
    if (typed) want = typed_want;
    pending_drives.push_back(want);
    n_samples++;
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain(input int unsigned ph);
    case (ph)
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [pet_pkg::SAMPLE_W-1:0] gen_sample;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($signed($urandom_range(0, 600)) - 300);
    if (r < 70) return 16'($signed($urandom_range(0, 8000)) - 4000);
    if (r < 92) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin : drive_check
    drive_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      n_drives++;
      if (pending_drives.size() == 0) begin
        $error("drive transfer with no sample pending: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_drives.pop_front();
        if (got.drive_signed !== want.drive_signed) begin
          $error("drive_signed: expected %0d, actual %0d", want.drive_signed,
                 got.drive_signed);
          err_cnt++;
        end
        if (got.drive_magnitude !== want.drive_magnitude) begin
          $error("drive_magnitude: expected %0d, actual %0d", want.drive_magnitude,
                 got.drive_magnitude);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("[pid_error_tracker] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    kp_q = '0; ki_q = '0; kd_q = '0;
    prop_q = '0; integ_q = '0; deriv_q = '0;
    last_q = '0; prev_q = '0; steps_q = '0; phase_q = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_gains(16'h8000, 16'h7fff, 16'h7fff);
    foreach (dir_rows[k]) begin
      send_sample(dir_rows[k].sample, dir_rows[k].typed,
                  {dir_rows[k].want_magnitude, dir_rows[k].want_signed});
    end
    s_axis_tvalid <= 1'b0;
    drain();

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      write_gains(pick_gain(ph), pick_gain(ph), pick_gain(ph));
      no_idle = (ph == 3);
      for (int unsigned n = 0; n < ITEMS_PER_PH; n++) begin
        if (ph == 5 && n == 40) hold_req = 1'b1;
        send_sample(gen_sample(), 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    $display("run: %0d samples, %0d drive transfers, %0d gain settings", n_samples,
             n_drives, n_settings);
    $display("run: crossed warmup into step counter saturation, %0d live integral updates",
             n_integ);
    if (err_cnt == 0) begin
      $display("[pid_error_tracker] OK");
    end else begin
      $display("[pid_error_tracker] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pet_pkg.sv
rtl/core/pet_mac.sv
rtl/core/pid_error_tracker.sv
tb/sv/tb_pid_error_tracker.sv
